// ===== rtl/amsd_pkg.sv =====
// Shared types, register codes and limits for the alpha mask dilation block.
package amsd_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_RADIUS = 16;
    localparam int HEIGHT_LIMIT   = 2048;

    localparam int ALPHA_W      = 8;
    localparam int POS_W        = 11;
    localparam int ROW_W        = 12;
    localparam int DIM_REG_W    = 12;
    localparam int RADIUS_REG_W = 5;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 12;
    localparam int OUTQ_DEPTH   = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DILATION_RADIUS = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_THRESHOLD = 4'd3;

    localparam logic [DIM_REG_W-1:0]    RST_IMAGE_WIDTH     = 12'd64;
    localparam logic [DIM_REG_W-1:0]    RST_IMAGE_HEIGHT    = 12'd64;
    localparam logic [RADIUS_REG_W-1:0] RST_DILATION_RADIUS = 5'd0;
    localparam logic [ALPHA_W-1:0]      RST_ALPHA_THRESHOLD = 8'd5;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               is_drain;
    } t_in_item;

    typedef struct packed {
        logic             occupied;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             run_end;
        logic             frame_end;
    } t_out_item;

    // One column operation handed from the sequencer to the history stage.
    typedef struct packed {
        logic             write;
        logic             hb;
        logic [ROW_W-1:0] y;
        logic             emit;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             fend;
        logic             run_end;
    } t_op;

endpackage

// ===== rtl/alpha_mask_square_dilation.sv =====
// Binary dilation of a thresholded alpha mask with a square window, clipped at the
// image edges, results in raster order with column and row. Each accepted item drives
// one column operation per cycle while the output queue has room, a read-modify-write
// of the per-column history memory. After a pixel that completes one column (or none)
// the block is ready for a new item when the queue has room; a pixel at the row end issues
// min(W, r+1) operations and a drain item up to MAX_RADIUS+1, one per emitted bit. Results
// pass through the history stage register and the output queue. After the last pixel of a
// frame the host sends drain items until a result with frame_end arrives; the last
// r rows come out that way. A write of width, height or radius restarts the frame.
module alpha_mask_square_dilation import amsd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int CW  = ((XW > RW) ? XW : RW) + 1;
    localparam int SW  = ((WW > RW) ? WW : RW) + 1;
    localparam int QCW = $clog2(OUTQ_DEPTH + 1);

    function automatic logic [XW-1:0] last_col_of(input logic [DIM_REG_W-1:0] w);
        logic [XW-1:0] res;
        if (w == '0) begin
            res = '0;
        end else if (32'(w) > MAX_WIDTH) begin
            res = XW'(MAX_WIDTH - 1);
        end else begin
            res = XW'(w - DIM_REG_W'(1));
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] last_row_of(input logic [DIM_REG_W-1:0] h);
        logic [POS_W-1:0] res;
        if (h == '0) begin
            res = '0;
        end else if (32'(h) > HEIGHT_LIMIT) begin
            res = POS_W'(HEIGHT_LIMIT - 1);
        end else begin
            res = POS_W'(h - DIM_REG_W'(1));
        end
        return res;
    endfunction

    function automatic logic [RW-1:0] radius_of(input logic [RADIUS_REG_W-1:0] v);
        logic [RW-1:0] res;
        if (32'(v) > MAX_RADIUS) begin
            res = RW'(MAX_RADIUS);
        end else begin
            res = RW'(v);
        end
        return res;
    endfunction

    // configuration, kept in effective (clamped) form
    logic [XW-1:0]      r_last_col;
    logic [POS_W-1:0]   r_last_row;
    logic [RW-1:0]      r_radius;
    logic [ALPHA_W-1:0] r_threshold;
    logic               geom_write;

    // frame position
    logic [XW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [WW-1:0]    r_row_win;
    logic [XW-1:0]    r_emit_col;
    logic [POS_W-1:0] r_emit_row;

    // column operation sequencer
    logic             r_busy;
    logic             r_drain;
    logic [XW-1:0]    r_x;
    logic [XW-1:0]    r_hi;
    logic [WW-1:0]    r_hwin;
    logic [ROW_W-1:0] r_y;
    logic             r_emit_en;
    logic [RW-1:0]    r_cnt;

    logic             credit;
    logic             pix_ok;
    logic             row_end;
    logic             mid_any;
    logic [XW-1:0]    lo_mid;
    logic [XW-1:0]    lo_end;
    logic [XW-1:0]    new_x;
    logic [WW-1:0]    new_hwin;
    logic             new_emit_en;
    logic             new_ops;
    logic             accept;
    logic             issue;

    logic             op_drain;
    logic [XW-1:0]    op_x;
    logic [XW-1:0]    op_hi;
    logic [WW-1:0]    op_hwin;
    logic [ROW_W-1:0] op_y;
    logic             op_emit_en;
    logic [RW-1:0]    op_cnt;
    logic             op_emit;
    logic [XW-1:0]    op_addr;
    logic             op_hb;
    logic             op_fend;
    logic             op_last;
    t_op              op;

    logic             s1_busy;
    logic             res_valid;
    t_out_item        res;
    logic [QCW-1:0]   q_count;

    assign o_cfg_ready = 1'b1;
    assign geom_write  = i_cfg_valid && ((i_cfg_index == REG_IMAGE_WIDTH) ||
                                         (i_cfg_index == REG_IMAGE_HEIGHT) ||
                                         (i_cfg_index == REG_DILATION_RADIUS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col  <= last_col_of(RST_IMAGE_WIDTH);
            r_last_row  <= last_row_of(RST_IMAGE_HEIGHT);
            r_radius    <= radius_of(RST_DILATION_RADIUS);
            r_threshold <= RST_ALPHA_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_last_col <= last_col_of(i_cfg_data);
                end
                REG_IMAGE_HEIGHT: begin
                    r_last_row <= last_row_of(i_cfg_data);
                end
                REG_DILATION_RADIUS: begin
                    r_radius <= radius_of(i_cfg_data[RADIUS_REG_W-1:0]);
                end
                REG_ALPHA_THRESHOLD: begin
                    r_threshold <= i_cfg_data[ALPHA_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // issue only when the queue can take everything already in flight
    assign credit = ((QCW+1)'(q_count) + (QCW+1)'(s1_busy)) < (QCW+1)'(OUTQ_DEPTH);

    // operations of a newly offered item
    always_comb begin
        pix_ok      = (r_in_row <= {1'b0, r_last_row});
        row_end     = (r_in_col == r_last_col);
        mid_any     = (CW'(r_in_col) >= CW'(r_radius));
        lo_mid      = XW'(CW'(r_in_col) - CW'(r_radius));
        lo_end      = (CW'(r_last_col) >= CW'(r_radius)) ?
                      XW'(CW'(r_last_col) - CW'(r_radius)) : '0;
        new_x       = row_end ? lo_end : lo_mid;
        if (i_in_data.alpha > r_threshold) begin
            new_hwin = WW'(r_in_col) + WW'(1);
        end else if (r_in_col == '0) begin
            new_hwin = '0;
        end else begin
            new_hwin = r_row_win;
        end
        new_emit_en = (r_in_row >= ROW_W'(r_radius));
        new_ops     = i_in_data.is_drain ? !pix_ok : (pix_ok && (row_end || mid_any));
    end

    assign o_in_ready = !r_busy && credit;
    assign accept     = i_in_valid && o_in_ready;
    assign issue      = r_busy ? credit : (accept && new_ops);

    // current operation, from the pending item or the one being accepted
    always_comb begin
        op_drain   = r_busy ? r_drain   : i_in_data.is_drain;
        op_x       = r_busy ? r_x       : new_x;
        op_hi      = r_busy ? r_hi      : (row_end ? r_last_col : new_x);
        op_hwin    = r_busy ? r_hwin    : new_hwin;
        op_y       = r_busy ? r_y       : r_in_row;
        op_emit_en = r_busy ? r_emit_en : new_emit_en;
        op_cnt     = r_busy ? r_cnt     : '0;
        op_emit    = op_drain || op_emit_en;
        op_addr    = op_drain ? r_emit_col : op_x;
        op_hb      = (op_hwin != '0) &&
                     (SW'(op_hwin) + SW'(r_radius) >= SW'(op_x) + SW'(1));
        op_fend    = op_emit && (r_emit_row == r_last_row) && (r_emit_col == r_last_col);
        op_last    = op_drain ? (op_fend || (op_cnt == RW'(MAX_RADIUS))) : (op_x == op_hi);

        op.write   = !op_drain;
        op.hb      = op_hb;
        op.y       = op_y;
        op.emit    = op_emit;
        op.col     = POS_W'(r_emit_col);
        op.row     = r_emit_row;
        op.fend    = op_fend;
        op.run_end = op_last && op_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_row_win  <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
            r_busy     <= 1'b0;
        end else begin
            if (accept && !i_in_data.is_drain && pix_ok) begin
                r_row_win <= new_hwin;
                if (row_end) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + XW'(1);
                end
            end
            if (issue) begin
                r_busy <= !op_last;
                if (op_emit) begin
                    if (r_emit_col == r_last_col) begin
                        r_emit_col <= '0;
                        r_emit_row <= r_emit_row + POS_W'(1);
                    end else begin
                        r_emit_col <= r_emit_col + XW'(1);
                    end
                end
            end
            // frame complete, or geometry changed: back to the frame start
            if ((issue && op_fend) || geom_write) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_row_win  <= '0;
                r_emit_col <= '0;
                r_emit_row <= '0;
            end
            if (geom_write) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drain   <= i_in_data.is_drain;
            r_hi      <= op_hi;
            r_hwin    <= new_hwin;
            r_y       <= r_in_row;
            r_emit_en <= new_emit_en;
        end
        if (issue) begin
            r_x   <= op_x + XW'(1);
            r_cnt <= op_cnt + RW'(1);
        end
    end

    amsd_colmem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_colmem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_addr      (op_addr),
        .i_op        (op),
        .i_radius    (r_radius),
        .o_s1_busy   (s1_busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    amsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_count (q_count),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && op_fend |=> (r_in_row == '0) && (r_emit_row == '0) &&
                             (r_emit_col == '0) && !r_busy)
        else $error("frame end did not restart the frame");

    a_drain_after_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_drain |-> (r_in_row > {1'b0, r_last_row}))
        else $error("drain burst running while pixels still expected");

    a_emit_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && !op_drain && op_emit |-> (op_x == r_emit_col))
        else $error("completed column and emit column out of step");

endmodule

// ===== rtl/amsd_colmem.sv =====
// Column history memory with read-modify-write stage and vertical OR.
module amsd_colmem import amsd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_issue,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_addr,
    input  t_op                                 i_op,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]     i_radius,
    output logic                                o_s1_busy,
    output logic                                o_res_valid,
    output t_out_item                           o_res
);
    localparam int XW = $clog2(MAX_WIDTH);

    logic [ROW_W-1:0] r_mem [MAX_WIDTH];
    logic [ROW_W-1:0] r_rd_data;
    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [XW-1:0]    r_s1_addr;
    logic             r_fwd_hit;
    logic [ROW_W-1:0] r_fwd_data;

    logic [ROW_W-1:0] old_hist;
    logic [ROW_W-1:0] n_hist;
    logic [ROW_W-1:0] hv;
    logic             occ;

    always_comb begin
        old_hist = r_fwd_hit ? r_fwd_data : r_rd_data;
        if (r_s1_op.y == '0) begin
            n_hist = ROW_W'(r_s1_op.hb);
        end else if (r_s1_op.hb) begin
            n_hist = r_s1_op.y + ROW_W'(1);
        end else begin
            n_hist = old_hist;
        end
        hv  = r_s1_op.write ? n_hist : old_hist;
        // last occupied row + 1 + r must reach the emitted row + 1
        occ = (hv != '0) &&
              ((ROW_W+1)'(hv) + (ROW_W+1)'(i_radius) >= (ROW_W+1)'(r_s1_op.row) + (ROW_W+1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_rd_data <= r_mem[i_addr];
        end
        if (r_s1_valid && r_s1_op.write) begin
            r_mem[r_s1_addr] <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
        end
    end

    // the memory reads old data on a same-cycle write, so bypass it
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1_op    <= i_op;
            r_s1_addr  <= i_addr;
            r_fwd_hit  <= r_s1_valid && r_s1_op.write && (r_s1_addr == i_addr);
            r_fwd_data <= n_hist;
        end
    end

    assign o_s1_busy   = r_s1_valid;
    assign o_res_valid = r_s1_valid && r_s1_op.emit;

    always_comb begin
        o_res.occupied  = occ;
        o_res.out_col   = r_s1_op.col;
        o_res.out_row   = r_s1_op.row;
        o_res.run_end   = r_s1_op.run_end;
        o_res.frame_end = r_s1_op.fend;
    end

endmodule

// ===== rtl/amsd_outq.sv =====
// Small output queue that decouples result items from downstream stalls.
module amsd_outq import amsd_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  t_out_item                         i_data,
    output logic [$clog2(OUTQ_DEPTH+1)-1:0]   o_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output t_out_item                         o_data
);
    localparam int PW  = $clog2(OUTQ_DEPTH);
    localparam int QCW = $clog2(OUTQ_DEPTH + 1);

    t_out_item        r_q [OUTQ_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(OUTQ_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(OUTQ_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + QCW'(i_push) - QCW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCW'(OUTQ_DEPTH)))
        else $error("output queue overflow");

endmodule
